/* hw/rtl/smbtr_pkg.sv */
// Shared types and constants for the SMBus thermometer read master.
// Used by smbtr_fsm and smbus_thermometer_read_master; no dependencies.
package smbtr_pkg;

	// Configuration register indexes
	localparam logic [1:0] CFG_ACK_POLL_LIMIT = 2'd0;
	localparam logic [1:0] CFG_RETRY_DELAY    = 2'd1;
	localparam logic [1:0] CFG_TEMP_OFFSET    = 2'd2;
	localparam logic [1:0] CFG_PEC_ENABLE     = 2'd3;

	// Reset values of the configuration registers
	localparam logic [7:0]         RST_ACK_POLL_LIMIT = 8'd10;
	localparam logic [15:0]        RST_RETRY_DELAY    = 16'd200;
	localparam logic signed [14:0] RST_TEMP_OFFSET    = 15'sd700;
	localparam logic               RST_PEC_ENABLE     = 1'b1;

	// CRC-8 polynomial for SMBus PEC
	localparam logic [7:0] CRC_POLY = 8'h07;

	// 273.15 degrees in hundredths, subtracted from the scaled raw reading
	localparam logic signed [18:0] KELVIN_CENTI = 19'sd27315;

	typedef struct packed {
		logic [7:0]         ack_poll_limit;
		logic [15:0]        retry_delay_ticks;
		logic signed [14:0] temp_offset_centi;
		logic               pec_check_enable;
	} cfg_t;

	typedef struct packed {
		logic       req_type;
		logic [6:0] device_addr;
		logic [7:0] register_addr;
		logic       sda_in;
	} item_t;

	typedef struct packed {
		logic               scl_level;
		logic               sda_level;
		logic               busy_res;
		logic               done_res;
		logic               pec_ok;
		logic signed [17:0] temperature_centi;
	} res_t;

	// One bit step of CRC-8, MSB first
	function automatic logic [7:0] crc_bit(input logic [7:0] crc, input logic b);
		logic fb;
		fb = crc[7] ^ b;
		return {crc[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
	endfunction

endpackage

/* hw/rtl/smbus_thermometer_read_master.sv */
// Top level of the SMBus thermometer read master: stream ports, config registers,
// input and result registers around smbtr_fsm. Depends on smbtr_pkg, smbtr_fsm.
//
//  channel | direction | handshake         | content
//  s_*     | in        | s_tvalid/s_tready | one half-bit tick, start request in tuser
//  m_*     | out       | m_tvalid/m_tready | bus levels and status per tick, done in tlast
//  cfg_*   | in        | cfg_we            | register index and write data
//
// A tick's result passes the input register, which holds the tick, and then the result
// register, loaded by the sequencer step. One tick is accepted every cycle unless stalled.
// arst_n clears the sequencer to idle with both lines released and restores defaults.
// A stalled result holds in place; input stalls once the input register is full and the
// result register is still held.
module smbus_thermometer_read_master (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // device_addr[6:0], register_addr[14:7], sda_in[15]
	input  logic        s_tuser,   // req_type[0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // scl_level[0], sda_level[1], busy_res[2], pec_ok[3],
	                               // temperature_centi[21:4], zero[23:22]
	output logic        m_tlast,   // done_res
	input  logic        cfg_we,
	input  logic [1:0]  cfg_idx,
	input  logic [15:0] cfg_wdata
);

	smbtr_pkg::cfg_t  cfg_q;
	smbtr_pkg::item_t item_s1;
	smbtr_pkg::res_t  res_c;
	logic             valid_s1;
	logic             adv;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ack_poll_limit    <= smbtr_pkg::RST_ACK_POLL_LIMIT;
			cfg_q.retry_delay_ticks <= smbtr_pkg::RST_RETRY_DELAY;
			cfg_q.temp_offset_centi <= smbtr_pkg::RST_TEMP_OFFSET;
			cfg_q.pec_check_enable  <= smbtr_pkg::RST_PEC_ENABLE;
		end else if (cfg_we) begin
			case (cfg_idx)
				smbtr_pkg::CFG_ACK_POLL_LIMIT: cfg_q.ack_poll_limit <= cfg_wdata[7:0];
				smbtr_pkg::CFG_RETRY_DELAY:    cfg_q.retry_delay_ticks <= cfg_wdata;
				smbtr_pkg::CFG_TEMP_OFFSET:    cfg_q.temp_offset_centi <= $signed(cfg_wdata[14:0]);
				smbtr_pkg::CFG_PEC_ENABLE:     cfg_q.pec_check_enable <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// Pipeline control
	assign adv      = valid_s1 && (!m_tvalid || m_tready);
	assign s_tready = !valid_s1 || adv;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.req_type      <= s_tuser;
			item_s1.device_addr   <= s_tdata[6:0];
			item_s1.register_addr <= s_tdata[14:7];
			item_s1.sda_in        <= s_tdata[15];
		end
	end

	smbtr_fsm u_fsm (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (adv),
		.item   (item_s1),
		.cfg    (cfg_q),
		.res    (res_c)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (adv) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			m_tdata <= {2'b00, res_c.temperature_centi, res_c.pec_ok, res_c.busy_res,
				res_c.sda_level, res_c.scl_level};
			m_tlast <= res_c.done_res;
		end
	end

	// A held input tick keeps its content until it steps
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !adv) |=> (valid_s1 && $stable(item_s1)))
		else $error("input register lost a pending tick");

	// A finishing tick never reports the bus as busy
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tlast) |-> !m_tdata[2])
		else $error("done reported while busy");

	// A step always leaves a result in the output register
	a_step_out: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> m_tvalid)
		else $error("step without a result");

endmodule

/* hw/rtl/smbtr_fsm.sv */
// Bus sequencer for the SMBus read-word transaction, one half-bit tick per step.
// Holds the transaction state; PEC is accumulated bit by bit. Depends on smbtr_pkg.
module smbtr_fsm (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  smbtr_pkg::item_t item,
	input  smbtr_pkg::cfg_t  cfg,
	output smbtr_pkg::res_t  res
);

	localparam logic [3:0] PH_IDLE    = 4'd0;
	localparam logic [3:0] PH_START0  = 4'd1;
	localparam logic [3:0] PH_START1  = 4'd2;
	localparam logic [3:0] PH_START2  = 4'd3;
	localparam logic [3:0] PH_TX_LO   = 4'd4;
	localparam logic [3:0] PH_TX_HI   = 4'd5;
	localparam logic [3:0] PH_ACK_LO  = 4'd6;
	localparam logic [3:0] PH_ACK_HI  = 4'd7;
	localparam logic [3:0] PH_STOP0   = 4'd8;
	localparam logic [3:0] PH_STOP1   = 4'd9;
	localparam logic [3:0] PH_STOP2   = 4'd10;
	localparam logic [3:0] PH_WAIT    = 4'd11;
	localparam logic [3:0] PH_RX_LO   = 4'd12;
	localparam logic [3:0] PH_RX_HI   = 4'd13;
	localparam logic [3:0] PH_MACK_LO = 4'd14;
	localparam logic [3:0] PH_MACK_HI = 4'd15;

	logic [3:0]       phase_q, phase_d;
	logic [3:0]       bit_q, bit_d;
	logic [7:0]       shift_q, shift_d;
	logic [1:0]       bidx_q, bidx_d;
	logic [2:0][7:0]  rb_q, rb_d;
	logic [7:0]       crc_q, crc_d;     // running PEC for the active read
	logic [7:0]       hdr_q, hdr_d;     // PEC over write address and register
	logic [7:0]       poll_q, poll_d;
	logic [15:0]      wait_q, wait_d;
	logic [6:0]       dev_q, dev_d;
	logic [7:0]       reg_q, reg_d;

	logic [3:0]         bit_inc;
	logic [7:0]         poll_inc;
	logic [15:0]        wait_inc;
	logic [7:0]         rx_byte;
	logic [1:0]         rb_idx;
	logic [15:0]        raw;
	logic signed [18:0] conv;
	logic signed [18:0] off_ext;

	assign bit_inc  = bit_q + 4'd1;
	assign poll_inc = poll_q + 8'd1;
	assign wait_inc = wait_q + 16'd1;
	assign rx_byte  = {shift_q[6:0], item.sda_in};
	assign rb_idx   = (bidx_q == 2'd3) ? 2'd2 : bidx_q;
	assign raw      = {rb_q[1], rb_q[0]};
	assign off_ext  = 19'(cfg.temp_offset_centi);
	assign conv     = $signed({2'b00, raw, 1'b0}) - smbtr_pkg::KELVIN_CENTI + off_ext;

	// Next-state and bus levels for one tick
	always_comb begin
		phase_d = phase_q;
		bit_d   = bit_q;
		shift_d = shift_q;
		bidx_d  = bidx_q;
		rb_d    = rb_q;
		crc_d   = crc_q;
		hdr_d   = hdr_q;
		poll_d  = poll_q;
		wait_d  = wait_q;
		dev_d   = dev_q;
		reg_d   = reg_q;
		res     = '0;
		res.scl_level = 1'b1;
		res.sda_level = 1'b1;
		res.busy_res  = 1'b1;
		case (phase_q)
			PH_START0: begin
				res.scl_level = 1'b0;
				phase_d = PH_START1;
			end
			PH_START1: begin
				phase_d = PH_START2;
			end
			PH_START2: begin
				res.sda_level = 1'b0;
				bit_d   = '0;
				phase_d = PH_TX_LO;
				case (bidx_q)
					2'd0:    shift_d = {dev_q, 1'b0};
					2'd1:    shift_d = reg_q;
					default: shift_d = {dev_q, 1'b1};
				endcase
				// read address is sent after the header and resent on retry: restart PEC from the header
				if (bidx_q == 2'd2) begin
					crc_d = hdr_q;
				end
			end
			PH_TX_LO: begin
				res.scl_level = 1'b0;
				res.sda_level = shift_q[7];
				phase_d = PH_TX_HI;
			end
			PH_TX_HI: begin
				res.sda_level = shift_q[7];
				shift_d = {shift_q[6:0], 1'b0};
				bit_d   = bit_inc;
				phase_d = (bit_inc >= 4'd8) ? PH_ACK_LO : PH_TX_LO;
				if (bidx_q == 2'd2) begin
					crc_d = smbtr_pkg::crc_bit(crc_q, shift_q[7]);
				end else begin
					hdr_d = smbtr_pkg::crc_bit(hdr_q, shift_q[7]);
				end
			end
			PH_ACK_LO: begin
				res.scl_level = 1'b0;
				poll_d  = '0;
				phase_d = PH_ACK_HI;
			end
			PH_ACK_HI: begin
				if (!item.sda_in) begin
					case (bidx_q)
						2'd0: begin
							bidx_d  = 2'd1;
							bit_d   = '0;
							shift_d = reg_q;
							phase_d = PH_TX_LO;
						end
						2'd1: begin
							bidx_d  = 2'd2;
							phase_d = PH_START0;
						end
						default: begin
							bidx_d  = 2'd0;
							bit_d   = '0;
							shift_d = '0;
							phase_d = PH_RX_LO;
						end
					endcase
				end else begin
					poll_d = poll_inc;
					if (poll_inc >= cfg.ack_poll_limit) begin
						phase_d = PH_STOP0;
					end
				end
			end
			PH_STOP0: begin
				res.scl_level = 1'b0;
				res.sda_level = 1'b0;
				phase_d = PH_STOP1;
			end
			PH_STOP1: begin
				res.sda_level = 1'b0;
				phase_d = PH_STOP2;
			end
			PH_STOP2: begin
				case (bidx_q)
					2'd0: begin
						// write address timed out: carry on with the register byte
						bidx_d  = 2'd1;
						bit_d   = '0;
						shift_d = reg_q;
						phase_d = PH_TX_LO;
					end
					2'd1: begin
						bidx_d  = 2'd2;
						phase_d = PH_START1;
					end
					2'd2: begin
						wait_d  = '0;
						phase_d = PH_WAIT;
					end
					default: begin
						// end of read: check PEC and convert; a failed checked PEC gives the offset alone
						res.busy_res = 1'b0;
						res.done_res = 1'b1;
						res.pec_ok   = (crc_q == rb_q[2]);
						if ((crc_q == rb_q[2]) || !cfg.pec_check_enable) begin
							res.temperature_centi = conv[17:0];
						end else begin
							res.temperature_centi = off_ext[17:0];
						end
						phase_d = PH_IDLE;
					end
				endcase
			end
			PH_WAIT: begin
				wait_d = wait_inc;
				if (wait_inc >= cfg.retry_delay_ticks) begin
					phase_d = PH_START1;
				end
			end
			PH_RX_LO: begin
				res.scl_level = 1'b0;
				phase_d = PH_RX_HI;
			end
			PH_RX_HI: begin
				shift_d = rx_byte;
				bit_d   = bit_inc;
				// data bytes join the PEC, the PEC byte itself does not
				if (bidx_q < 2'd2) begin
					crc_d = smbtr_pkg::crc_bit(crc_q, item.sda_in);
				end
				if (bit_inc >= 4'd8) begin
					rb_d[rb_idx] = rx_byte;
					phase_d = PH_MACK_LO;
				end else begin
					phase_d = PH_RX_LO;
				end
			end
			PH_MACK_LO: begin
				res.scl_level = 1'b0;
				res.sda_level = (bidx_q >= 2'd2);
				phase_d = PH_MACK_HI;
			end
			PH_MACK_HI: begin
				res.sda_level = (bidx_q >= 2'd2);
				if (bidx_q >= 2'd2) begin
					bidx_d  = 2'd3;
					phase_d = PH_STOP0;
				end else begin
					bidx_d  = bidx_q + 2'd1;
					bit_d   = '0;
					shift_d = '0;
					phase_d = PH_RX_LO;
				end
			end
			default: begin
				phase_d = PH_IDLE;
				if (item.req_type) begin
					dev_d   = item.device_addr;
					reg_d   = item.register_addr;
					bidx_d  = 2'd0;
					bit_d   = '0;
					poll_d  = '0;
					wait_d  = '0;
					hdr_d   = '0;
					phase_d = PH_START2;
				end else begin
					res.busy_res = 1'b0;
				end
			end
		endcase
	end

	// State registers, advanced once per accepted tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			bit_q   <= '0;
			shift_q <= '0;
			bidx_q  <= '0;
			rb_q    <= '0;
			crc_q   <= '0;
			hdr_q   <= '0;
			poll_q  <= '0;
			wait_q  <= '0;
			dev_q   <= '0;
			reg_q   <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			bit_q   <= bit_d;
			shift_q <= shift_d;
			bidx_q  <= bidx_d;
			rb_q    <= rb_d;
			crc_q   <= crc_d;
			hdr_q   <= hdr_d;
			poll_q  <= poll_d;
			wait_q  <= wait_d;
			dev_q   <= dev_d;
			reg_q   <= reg_d;
		end
	end

	// Bit counter never passes one byte
	a_bit_range: assert property (@(posedge clk) disable iff (!arst_n)
		bit_q <= 4'd8)
		else $error("bit counter out of range");

	// Byte index three only exists from the final nack through the stop sequence and in idle
	a_bidx_final: assert property (@(posedge clk) disable iff (!arst_n)
		(bidx_q == 2'd3) |-> (phase_q == PH_STOP0 || phase_q == PH_STOP1 ||
			phase_q == PH_STOP2 || phase_q == PH_IDLE))
		else $error("final byte index outside stop sequence");

	// A finished transaction returns to idle with the step that reports done
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(step && res.done_res) |=> (phase_q == PH_IDLE))
		else $error("done without return to idle");

	// Clock line is low on the transmit, receive and ack low half-bit phases
	a_scl_low: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_TX_LO || phase_q == PH_RX_LO || phase_q == PH_ACK_LO)
		|-> !res.scl_level)
		else $error("clock released in a low phase");

endmodule
